// ===== rtl/hsm_pkg.sv =====
`timescale 1ns / 1ps
package hsm_pkg;
    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_MULT  = 64'h00000100000001b3;
    localparam int COUNT_W = 13;
    localparam logic [12:0] COUNT_MAX = 13'd8191;

    typedef enum logic [1:0] {
        ST_PRESENT  = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic        action;
        logic [63:0] key_low;
        logic [63:0] key_mid;
        logic [31:0] key_high;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] key_low;
        logic [63:0] key_mid;
        logic [31:0] key_high;
    } slot_t;
endpackage

// ===== rtl/hsm_ram.sv =====
`timescale 1ns / 1ps
module hsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/hsm_hash.sv =====
`timescale 1ns / 1ps
module hsm_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  hsm_pkg::req_t req,
    output logic        done,
    output logic [63:0] hash
);
    import hsm_pkg::*;

    // One FNV round per cycle. P = 2^40 + 0x1b3, so h*P = (h << 40) + h*0x1b3
    // and only a 64x9 product is needed. Hold the upper key words from the
    // transfer, since the request port may change afterwards.
    logic [1:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] mid_reg;
    logic [31:0] high_reg;
    logic [63:0] mix;
    logic [63:0] prod;
    logic [63:0] word;

    always_comb
    begin
        case (round_reg)
            2'd0:    word = req.key_low;
            2'd1:    word = mid_reg;
            default: word = {32'd0, high_reg};
        endcase
        mix  = (load ? FNV_OFFSET : h_reg) ^ word;
        prod = (mix << 40) + mix * 64'h1b3;
        busy_next  = busy_reg;
        round_next = round_reg;
        h_next     = h_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            round_next = 2'd1;
            h_next     = prod;
        end
        else if (busy_reg)
        begin
            h_next = prod;
            if (round_reg == 2'd2)
            begin
                busy_next  = 1'b0;
                round_next = 2'd0;
            end
            else
            begin
                round_next = round_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        if (load)
        begin
            mid_reg  <= req.key_mid;
            high_reg <= req.key_high;
        end
    end

    assign done = busy_reg && (round_reg == 2'd2);
    assign hash = prod;
endmodule

// ===== rtl/hash_set_membership_160_core.sv =====
`timescale 1ns / 1ps
// Channel | Signals                 | Transfer
// command | start, busy, req        | start && !busy
// result  | rsp_valid, rsp          | rsp_valid (one cycle)
// The hash starts in the transfer cycle; each probed slot then takes a
// memory read state and a compare state, and the result state and an idle
// state follow. At most PROBE_LIMIT slots are probed per item.
// After reset a clearing pass writes every slot with busy high.
// The receiver cannot stall; results never wait.
module hash_set_membership_160_core #(
    parameter int SLOTS       = 4096,
    parameter int PROBE_LIMIT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hsm_pkg::req_t req,
    output logic          rsp_valid,
    output hsm_pkg::rsp_t rsp
);
    import hsm_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam int SW = $bits(slot_t);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CMP   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    req_t           req_reg;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [PW-1:0]  probe_reg, probe_next;
    logic [12:0]    count_reg, count_next;
    logic [1:0]     status_reg, status_next;
    logic           we;
    logic [AW-1:0]  waddr;
    slot_t          wdata, rdata;
    logic           hash_done;
    logic [63:0]    hash;
    logic           match;

    hsm_hash u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .load (start && !busy),
        .req  (req),
        .done (hash_done),
        .hash (hash)
    );

    hsm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(addr_reg),
        .rdata(rdata)
    );

    assign match = rdata.key_low == req_reg.key_low && rdata.key_mid == req_reg.key_mid
                   && rdata.key_high == req_reg.key_high;

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        probe_next  = probe_reg;
        count_next  = count_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = addr_reg;
        wdata       = '{valid: 1'b1, key_low: req_reg.key_low,
                        key_mid: req_reg.key_mid, key_high: req_reg.key_high};
        case (state_reg)
            S_CLEAR:
            begin
                we         = 1'b1;
                wdata      = '0;
                addr_next  = addr_reg + 1'b1;
                if (addr_reg == AW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    addr_next  = hash[AW-1:0];
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DONE;
                if (!rdata.valid)
                begin
                    if (req_reg.action)
                    begin
                        we          = 1'b1;
                        status_next = ST_INSERTED;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 13'd1;
                        end
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                else if (match)
                begin
                    status_next = ST_PRESENT;
                end
                else if (probe_reg == PW'(PROBE_LIMIT - 1))
                begin
                    status_next = req_reg.action ? ST_FULL : ST_ABSENT;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            probe_reg  <= '0;
            count_reg  <= '0;
            status_reg <= ST_ABSENT;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            probe_reg  <= probe_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    assign busy            = state_reg != S_IDLE;
    assign rsp_valid       = state_reg == S_DONE;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = count_reg;

    a_hash_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("hash finished outside hash state");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(we) && $past(state_reg) == S_CMP)
        else $error("count moved without an insert");
    a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_INSERTED |-> $past(we))
        else $error("insert reported without write");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !we)
        else $error("memory write while idle");
endmodule

// ===== tb/tb_hash_set_membership_160_core.sv =====
`timescale 1ns / 1ps
module tb_hash_set_membership_160_core;
    import hsm_pkg::*;

    localparam int SLOTS       = 4096;
    localparam int PROBE_LIMIT = 8;
    localparam int TAIL_CYCLES = 3 + 2 * PROBE_LIMIT + 8;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  rsp_valid;
    rsp_t  rsp;

    hash_set_membership_160_core #(
        .SLOTS(SLOTS),
        .PROBE_LIMIT(PROBE_LIMIT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp(rsp)
    );

    // shadow table
    logic        shadow_valid [SLOTS];
    logic [63:0] shadow_low   [SLOTS];
    logic [63:0] shadow_mid   [SLOTS];
    logic [31:0] shadow_high  [SLOTS];
    logic [12:0] shadow_count;

    req_t pending_cmds [$];
    rsp_t expected_rsps [$];
    int   mismatch_count;
    int   gap_left;
    int   accepted_cmds;
    int   inserts_seen, fulls_seen, hits_seen;
    bit   gaps_enabled;
    req_t key_pool [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] fnv_key(input req_t r);
        logic [63:0] h;
        begin
            h = FNV_OFFSET;
            h = (h ^ r.key_low) * HASH_MULT;
            h = (h ^ r.key_mid) * HASH_MULT;
            h = (h ^ {32'd0, r.key_high}) * HASH_MULT;
            return h;
        end
    endfunction

    function automatic rsp_t predict_membership(input req_t r);
        rsp_t        o;
        int          home;
        int          s;
        logic [1:0]  st;
        begin
            home = int'(fnv_key(r) % SLOTS);
            st = r.action ? ST_FULL : ST_ABSENT;
            for (int n = 0; n < PROBE_LIMIT; n++)
            begin
                s = (home + n) % SLOTS;
                if (!shadow_valid[s])
                begin
                    if (r.action)
                    begin
                        shadow_valid[s] = 1'b1;
                        shadow_low[s]   = r.key_low;
                        shadow_mid[s]   = r.key_mid;
                        shadow_high[s]  = r.key_high;
                        if (shadow_count < COUNT_MAX)
                            shadow_count++;
                        st = ST_INSERTED;
                    end
                    else
                        st = ST_ABSENT;
                    break;
                end
                if (shadow_low[s] == r.key_low && shadow_mid[s] == r.key_mid &&
                    shadow_high[s] == r.key_high)
                begin
                    st = ST_PRESENT;
                    break;
                end
            end
            o.status      = st;
            o.entry_count = shadow_count;
            return o;
        end
    endfunction

    task automatic report_mismatch(input string what);
        begin
            $display("mismatch at %0t: %s", $time, what);
            mismatch_count++;
        end
    endtask

    function automatic req_t rand_key(input logic act);
        req_t r;
        begin
            r.action   = act;
            r.key_low  = {$urandom, $urandom};
            r.key_mid  = {$urandom, $urandom};
            r.key_high = $urandom;
            return r;
        end
    endfunction

    // Build keys that share a home slot so probing chains fill up.
    function automatic req_t colliding_key(input int home, input logic act);
        req_t r;
        begin
            do
                r = rand_key(act);
            while (int'(fnv_key(r) % SLOTS) != home);
            return r;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            req      <= '0;
            gap_left <= 0;
        end
        else if (!(start && busy))
        begin
            // previous transfer done (or nothing driven); pick next
            if (start)
            begin
                expected_rsps.push_back(predict_membership(req));
                accepted_cmds++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 7) == 0)
            begin
                gap_left <= $urandom_range(0, 11);
                start    <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                req   <= pending_cmds.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.status !== e.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, e.status));
                if (rsp.entry_count !== e.entry_count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              rsp.entry_count, e.entry_count));
                case (e.status)
                    ST_INSERTED: inserts_seen++;
                    ST_FULL:     fulls_seen++;
                    ST_PRESENT:  hits_seen++;
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        req_t r;
        int   home;
        for (int i = 0; i < SLOTS; i++)
            shadow_valid[i] = 1'b0;
        shadow_count   = '0;
        mismatch_count = 0;
        accepted_cmds  = 0;
        inserts_seen   = 0;
        fulls_seen     = 0;
        hits_seen      = 0;
        gaps_enabled   = 1'b1;
        rst_n = 1'b0;

        // directed: extremes, insert, duplicate, lookup miss
        r = '0;                                    pending_cmds.push_back(r);
        r.action = 1'b1;                           pending_cmds.push_back(r);
        pending_cmds.push_back(r);
        r.action = 1'b0;                           pending_cmds.push_back(r);
        r = '1; r.action = 1'b0;                   pending_cmds.push_back(r);
        r.action = 1'b1;                           pending_cmds.push_back(r);
        r.action = 1'b0;                           pending_cmds.push_back(r);
        // fill one probe chain past its limit, then look up around it
        home = SLOTS - 3;  // chain wraps the table end
        for (int i = 0; i < PROBE_LIMIT + 2; i++)
        begin
            r = colliding_key(home, 1'b1);
            key_pool.push_back(r);
            pending_cmds.push_back(r);
        end
        for (int i = 0; i < key_pool.size(); i++)
        begin
            r = key_pool[i];
            r.action = 1'b0;
            pending_cmds.push_back(r);
        end
        pending_cmds.push_back(colliding_key(home, 1'b0));

        // random: mostly fresh inserts and lookups, reuse stored keys often
        for (int i = 0; i < 500; i++)
        begin
            if (key_pool.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                r = key_pool[$urandom_range(0, key_pool.size() - 1)];
                r.action = 1'($urandom_range(0, 1));
            end
            else if ($urandom_range(0, 9) == 0)
                r = colliding_key(int'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            else
                r = rand_key(1'($urandom_range(0, 1)));
            if (r.action)
                key_pool.push_back(r);
            pending_cmds.push_back(r);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() < 60);
        gaps_enabled = 1'b0;
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (start || busy)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d commands: %0d inserts, %0d hits, %0d table-full results",
                 accepted_cmds, inserts_seen, hits_seen, fulls_seen);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== hash_set_membership_160_core.f =====
rtl/hsm_pkg.sv
rtl/hsm_ram.sv
rtl/hsm_hash.sv
rtl/hash_set_membership_160_core.sv
tb/tb_hash_set_membership_160_core.sv
